// ===== rtl/oneshot_timer_table_core_macros.svh =====
// Assertion macros used by the checker of the one-shot timer table.
`ifndef ONESHOT_TIMER_TABLE_CORE_MACROS_SVH
`define ONESHOT_TIMER_TABLE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define OSTT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ostt checker: same-cycle property failed");

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define OSTT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ostt checker: next-cycle property failed");

`endif

// ===== rtl/ostt_pkg.sv =====
// Shared constants and types of the one-shot timer table.
package ostt_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

  localparam int ID_W   = 31;
  localparam int TICK_W = 64;
  localparam int DUR_W  = 32;
  localparam int MPT_W  = 20;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;

  localparam logic [ID_W-1:0]  ID_MAX    = {ID_W{1'b1}};
  localparam logic [ID_W-1:0]  ID_FIRST  = ID_W'(1);
  localparam logic [MPT_W-1:0] MPT_RESET = MPT_W'(1000);

  // Durations are scaled from milliseconds to microseconds before the divide.
  localparam int SCALE_W  = 10;
  localparam int SCALED_W = DUR_W + SCALE_W;
  localparam logic [SCALED_W-1:0] MS_TO_US = SCALED_W'(1000);
  localparam int DIV_CNT_W = $clog2(SCALED_W + 1);

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (STAT_W + ID_W + 1);
  localparam int IN_PAD_W    = IN_TDATA_W - (DUR_W + ID_W);

  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CREATE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

  localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_NO_FREE = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_UNKNOWN = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_UNUSED  = 2'd3;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic              live;
    logic [ID_W-1:0]   ident;
    logic [TICK_W-1:0] end_tick;
  } slot_wr_t;

  typedef struct packed {
    logic              live;
    logic [ID_W-1:0]   ident;
    logic [TICK_W-1:0] end_tick;
  } slot_rd_t;

endpackage

// ===== rtl/ostt_divider.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
module ostt_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ostt_pkg::SCALED_W-1:0] dividend,
  input  logic [ostt_pkg::MPT_W-1:0]    divisor,
  output logic                          done,
  output logic [ostt_pkg::SCALED_W-1:0] quotient
);
  import ostt_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SCALED_W-1:0]  quo_r, quo_nxt;
  logic [MPT_W-1:0]     rem_r, rem_nxt;
  logic [MPT_W-1:0]     dsr_r, dsr_nxt;
  logic [MPT_W:0]       trial;
  logic [MPT_W:0]       diff;
  logic                 ge;

  // The dividend shifts out of the top of quo_r while quotient bits shift in.
  assign trial = {rem_r, quo_r[SCALED_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = trial >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(SCALED_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[MPT_W-1:0] : trial[MPT_W-1:0];
      quo_nxt = {quo_r[SCALED_W-2:0], ge};
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/ostt_slot_table.sv =====
// Timer slot store: id and end-tick memory with per-slot live bits.
module ostt_slot_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [ostt_pkg::SLOT_W-1:0] rd_addr,
  output ostt_pkg::slot_rd_t          rd_data,
  input  ostt_pkg::slot_wr_t          wr
);
  import ostt_pkg::*;

  logic [ID_W-1:0]   ident_mem [SLOT_COUNT];
  logic [TICK_W-1:0] end_mem   [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] live_r;
  logic              rd_live_r;
  logic [ID_W-1:0]   rd_ident_r;
  logic [TICK_W-1:0] rd_end_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      ident_mem[wr.addr] <= wr.ident;
      end_mem[wr.addr]   <= wr.end_tick;
    end
    if (rd_en) begin
      rd_ident_r <= ident_mem[rd_addr];
      rd_end_r   <= end_mem[rd_addr];
    end
  end

  // Live bits clear at reset, so a slot never written reads as free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r    <= '0;
      rd_live_r <= 1'b0;
    end else begin
      if (wr.en) begin
        live_r[wr.addr] <= wr.live;
      end
      if (rd_en) begin
        rd_live_r <= live_r[rd_addr];
      end
    end
  end

  assign rd_data.live     = rd_live_r;
  assign rd_data.ident    = rd_ident_r;
  assign rd_data.end_tick = rd_end_r;

endmodule

// ===== rtl/oneshot_timer_table_core.sv =====
// Top level of the one-shot timer table: sequencer, tick counter and result register.
//
// The block keeps a 64-bit tick count and a table of SLOT_COUNT one-shot timers. Every
// input word carries a function code in in_tuser: tick, create or query; every input
// word yields exactly one result word. A tick, an unused code or a query of id 0 goes
// from idle straight to the response state, which loads the result word into the
// output register once that register is free or being read. A query walks the slot
// memory one entry per cycle until it finds the id or has checked the last slot; a
// create walks it for the first free slot and then runs the serial divider, one
// quotient bit per cycle over 42 bits. The slot memory has a single read port, so the
// scan reads one slot at a time. The block takes one input word at a time, but the
// next word is accepted while a finished result still waits in the output register.
// Slot live bits clear at reset, so there is no clearing pass. The micros_per_tick
// register is written through the cfg channel, which is always ready; a value of zero
// divides as one.
module oneshot_timer_table_core (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata, lowest bit up: duration_ms[31:0], query_id[62:32], zero pad [63].
  input  logic [ostt_pkg::IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: func[1:0].
  input  logic [ostt_pkg::FUNC_W-1:0]      in_tuser,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // out_tdata, lowest bit up: status[1:0], new_id[32:2], done_res[33], zero pad [39:34].
  output logic [ostt_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [ostt_pkg::MPT_W-1:0]       cfg_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready
);
  import ostt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_RESP = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [TICK_W-1:0]   tick_r, tick_nxt;
  logic [ID_W-1:0]     next_id_r, next_id_nxt;
  logic [MPT_W-1:0]    mpt_r, mpt_nxt;
  logic [FUNC_W-1:0]   func_r, func_nxt;
  logic [ID_W-1:0]     qid_r, qid_nxt;
  logic [SCALED_W-1:0] scaled_r, scaled_nxt;

  // Scan pointers: iss_r is the address being read, chk_r the one whose data is back.
  logic [SLOT_W-1:0]   iss_r, iss_nxt;
  logic                iss_left_r, iss_left_nxt;
  logic                pend_r, pend_nxt;
  logic [SLOT_W-1:0]   chk_r, chk_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;

  logic [STAT_W-1:0]   res_status_r, res_status_nxt;
  logic [ID_W-1:0]     res_id_r, res_id_nxt;
  logic                res_done_r, res_done_nxt;

  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic [FUNC_W-1:0]   in_func;
  logic [DUR_W-1:0]    in_dur;
  logic [ID_W-1:0]     in_qid;

  logic                rd_en;
  slot_rd_t            rd_data;
  slot_wr_t            wr;

  logic                div_start;
  logic                div_done;
  logic [SCALED_W-1:0] div_quot;
  logic [MPT_W-1:0]    div_divisor;

  assign in_func = in_tuser;
  assign in_dur  = in_tdata[DUR_W-1:0];
  assign in_qid  = in_tdata[DUR_W+ID_W-1:DUR_W];

  assign div_divisor = (mpt_r == '0) ? MPT_W'(1) : mpt_r;

  always_comb begin
    state_nxt      = state_r;
    tick_nxt       = tick_r;
    next_id_nxt    = next_id_r;
    mpt_nxt        = mpt_r;
    func_nxt       = func_r;
    qid_nxt        = qid_r;
    scaled_nxt     = scaled_r;
    iss_nxt        = iss_r;
    iss_left_nxt   = iss_left_r;
    pend_nxt       = pend_r;
    chk_nxt        = chk_r;
    slot_nxt       = slot_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_done_nxt   = res_done_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r;
    rd_en          = 1'b0;
    wr             = '0;
    div_start      = 1'b0;

    if (cfg_valid) begin
      mpt_nxt = cfg_data;
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          func_nxt       = in_func;
          qid_nxt        = in_qid;
          // Milliseconds to microseconds; the product fits in 42 bits.
          scaled_nxt     = {{SCALE_W{1'b0}}, in_dur} * MS_TO_US;
          iss_nxt        = '0;
          iss_left_nxt   = 1'b1;
          pend_nxt       = 1'b0;
          res_status_nxt = STATUS_OK;
          res_id_nxt     = '0;
          res_done_nxt   = 1'b0;
          case (in_func)
            FUNC_TICK: begin
              tick_nxt  = tick_r + TICK_W'(1);
              state_nxt = ST_RESP;
            end
            FUNC_CREATE: begin
              state_nxt = ST_SCAN;
            end
            FUNC_QUERY: begin
              // Id zero names no timer, even though freed slots hold it.
              if (in_qid == '0) begin
                res_status_nxt = STATUS_UNKNOWN;
                state_nxt      = ST_RESP;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end

      ST_SCAN: begin
        rd_en    = iss_left_r;
        pend_nxt = iss_left_r;
        chk_nxt  = iss_r;
        if (iss_left_r) begin
          if (iss_r == SLOT_LAST) begin
            iss_left_nxt = 1'b0;
          end else begin
            iss_nxt = iss_r + SLOT_W'(1);
          end
        end
        if (pend_r) begin
          if (func_r == FUNC_CREATE) begin
            if (!rd_data.live) begin
              slot_nxt  = chk_r;
              div_start = 1'b1;
              state_nxt = ST_DIV;
            end else if (chk_r == SLOT_LAST) begin
              res_status_nxt = STATUS_NO_FREE;
              state_nxt      = ST_RESP;
            end
          end else begin
            // The lowest slot holding the id wins when ids repeat after a wrap.
            if (rd_data.live && (rd_data.ident == qid_r)) begin
              if (rd_data.end_tick <= tick_r) begin
                wr.en        = 1'b1;
                wr.addr      = chk_r;
                wr.live      = 1'b0;
                res_done_nxt = 1'b1;
              end
              state_nxt = ST_RESP;
            end else if (chk_r == SLOT_LAST) begin
              res_status_nxt = STATUS_UNKNOWN;
              state_nxt      = ST_RESP;
            end
          end
        end
      end

      ST_DIV: begin
        if (div_done) begin
          wr.en       = 1'b1;
          wr.addr     = slot_r;
          wr.live     = 1'b1;
          wr.ident    = next_id_r;
          wr.end_tick = tick_r + TICK_W'(div_quot);
          res_id_nxt  = next_id_r;
          next_id_nxt = (next_id_r == ID_MAX) ? ID_FIRST : next_id_r + ID_W'(1);
          state_nxt   = ST_RESP;
        end
      end

      ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {{OUT_PAD_W{1'b0}}, res_done_r, res_id_r, res_status_r};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tick_r      <= '0;
      next_id_r   <= ID_FIRST;
      mpt_r       <= MPT_RESET;
      iss_left_r  <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      next_id_r   <= next_id_nxt;
      mpt_r       <= mpt_nxt;
      iss_left_r  <= iss_left_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r       <= func_nxt;
    qid_r        <= qid_nxt;
    scaled_r     <= scaled_nxt;
    iss_r        <= iss_nxt;
    chk_r        <= chk_nxt;
    slot_r       <= slot_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_done_r   <= res_done_nxt;
    out_data_r   <= out_data_nxt;
  end

  ostt_slot_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (iss_r),
    .rd_data (rd_data),
    .wr      (wr)
  );

  ostt_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (scaled_r),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

endmodule

// ===== rtl/ostt_checker.sv =====
// Port-level checker of the one-shot timer table and its bind to the top level.
`include "oneshot_timer_table_core_macros.svh"

module ostt_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [ostt_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tvalid,
  input logic                             out_tready
);
  import ostt_pkg::*;

  logic [STAT_W-1:0] o_status;
  logic [ID_W-1:0]   o_id;
  logic              o_done;

  assign o_status = out_tdata[STAT_W-1:0];
  assign o_id     = out_tdata[STAT_W+ID_W-1:STAT_W];
  assign o_done   = out_tdata[STAT_W+ID_W];

  // A stalled result word must not change.
  `OSTT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // The block works on one input word at a time.
  `OSTT_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)

  // An error result carries neither an id nor a done flag, and never the unused status.
  `OSTT_ASSERT_NOW(a_error_clean, out_tvalid && (o_status != STATUS_OK),
                   (o_id == '0) && !o_done && (o_status != STATUS_UNUSED))

  // A created timer and an expired query never share a result word.
  `OSTT_ASSERT_NOW(a_id_or_done, out_tvalid && (o_id != '0), !o_done)

endmodule

bind oneshot_timer_table_core ostt_checker u_ostt_checker (.*);

// ===== bench/tb_top.sv =====
// Self-checking testbench for the one-shot timer table core.
module tb_top;
  import ostt_pkg::*;

  // The one function code that the block must answer without touching its state.
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

  // Generous watchdog for a run of roughly a thousand words.
  localparam int CYCLE_LIMIT = 600000;
  // Longest create: the slot walk plus the serial divide, with some margin.
  localparam int DRAIN_CYCLES = SLOT_COUNT + 60;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   new_id;
    logic              done_res;
  } timer_outcome_t;

  typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_CHOKED} rx_style_t;

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic [FUNC_W-1:0]      in_tuser  = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [MPT_W-1:0]       cfg_data  = '0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;

  oneshot_timer_table_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_data  (cfg_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
  );

  // Shadow copy of the block's state, advanced once per accepted input word.
  logic [MPT_W-1:0]  tick_period_us = MPT_RESET;
  logic [TICK_W-1:0] clock_ticks    = '0;
  logic [ID_W-1:0]   ident_to_issue = ID_FIRST;
  logic [ID_W-1:0]   table_ident    [SLOT_COUNT];
  logic [TICK_W-1:0] table_deadline [SLOT_COUNT];
  logic [ID_W-1:0]   last_issued    = '0;
  logic [ID_W-1:0]   last_freed     = '0;

  // Outcomes predicted at acceptance, waiting for their result words in order.
  timer_outcome_t pending_outcomes[$];

  int errors       = 0;
  int cycles       = 0;
  int burst_left   = 0;
  int n_ticks      = 0;
  int n_creates    = 0;
  int n_queries    = 0;
  int n_spare      = 0;
  int n_table_full = 0;
  int n_unknown    = 0;
  int n_expired    = 0;
  int n_periods    = 0;

  rx_style_t rx_style = RX_OPEN;
  int        rx_left  = 0;

  initial begin
    for (int k = 0; k < SLOT_COUNT; k++) begin
      table_ident[k]    = '0;
      table_deadline[k] = '0;
    end
  end

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycles, pending_outcomes.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Works out the result of one word and moves the shadow state on. A create takes
  // the lowest free slot; its deadline is now plus ms*1000 over the tick period, with
  // a zero period dividing as one. A query frees the slot once the deadline is reached.
  task automatic predict_timer_outcome(input logic [FUNC_W-1:0] fn,
                                       input logic [DUR_W-1:0] dur,
                                       input logic [ID_W-1:0] qid,
                                       output timer_outcome_t r);
    int          hit;
    logic [63:0] divisor;
    r   = '{status: STATUS_OK, new_id: '0, done_res: 1'b0};
    hit = -1;
    case (fn)
      FUNC_TICK: begin
        clock_ticks = clock_ticks + 64'd1;
        n_ticks++;
      end
      FUNC_CREATE: begin
        n_creates++;
        for (int k = SLOT_COUNT - 1; k >= 0; k--)
          if (table_ident[k] == '0) hit = k;
        if (hit < 0) begin
          r.status = STATUS_NO_FREE;
          n_table_full++;
        end else begin
          divisor             = (tick_period_us == '0) ? 64'd1 : 64'(tick_period_us);
          table_ident[hit]    = ident_to_issue;
          table_deadline[hit] = clock_ticks + (64'(dur) * 64'd1000) / divisor;
          r.new_id            = ident_to_issue;
          last_issued         = ident_to_issue;
          ident_to_issue      = (ident_to_issue == ID_MAX) ? ID_FIRST
                                                           : ident_to_issue + ID_W'(1);
        end
      end
      FUNC_QUERY: begin
        n_queries++;
        // Free slots hold id 0, so id 0 must never be looked up.
        if (qid != '0)
          for (int k = SLOT_COUNT - 1; k >= 0; k--)
            if (table_ident[k] == qid) hit = k;
        if (hit < 0) begin
          r.status = STATUS_UNKNOWN;
          n_unknown++;
        end else if (table_deadline[hit] <= clock_ticks) begin
          last_freed          = table_ident[hit];
          table_ident[hit]    = '0;
          table_deadline[hit] = '0;
          r.done_res          = 1'b1;
          n_expired++;
        end
      end
      default: n_spare++;
    endcase
  endtask

  // Sends one input word. The sender runs in bursts; between bursts it drops valid
  // for a random pause, and now and then a long burst keeps the block busy back to back.
  task automatic send_word(input logic [FUNC_W-1:0] fn, input logic [DUR_W-1:0] dur,
                           input logic [ID_W-1:0] qid);
    timer_outcome_t o;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    in_tuser  <= fn;
    in_tdata  <= {{IN_PAD_W{1'b0}}, qid, dur};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_timer_outcome(fn, dur, qid, o);
    pending_outcomes.push_back(o);
  endtask

  // Stops sending and waits until every predicted result has come back.
  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_outcomes.size() != 0);
  endtask

  // Writes the tick period. Only called with the block idle.
  task automatic set_tick_period(input logic [MPT_W-1:0] period);
    cfg_data  <= period;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tick_period_us = period;
    n_periods++;
  endtask

  // Durations are mostly chosen so that timers run out within about two dozen ticks at
  // the current period; a rare full-range one stays in the table for good.
  function automatic logic [DUR_W-1:0] pick_duration();
    logic [63:0] period;
    int          sel;
    period = (tick_period_us == '0) ? 64'd1 : 64'(tick_period_us);
    sel    = $urandom_range(0, 199);
    if (sel < 1) return $urandom();
    if (sel < 20) return DUR_W'($urandom_range(0, 3));
    return DUR_W'((64'($urandom_range(0, 24)) * period) / 64'd1000);
  endfunction

  // Queries mostly name a live timer; the rest ask for a freed id, id 0 or noise.
  function automatic logic [ID_W-1:0] pick_query_id();
    logic [ID_W-1:0] live[$];
    int              sel;
    for (int k = 0; k < SLOT_COUNT; k++)
      if (table_ident[k] != '0) live.push_back(table_ident[k]);
    sel = $urandom_range(0, 99);
    if (sel < 70 && live.size() != 0) return live[$urandom_range(0, live.size() - 1)];
    if (sel < 80) return last_freed;
    if (sel < 88) return '0;
    return ID_W'($urandom());
  endfunction

  // Result checker and receiver. The receiver changes its manner every so often:
  // always ready, ready at random with a chance of two in three, or with a chance of one in eight.
  always @(posedge clk) begin : check_results
    timer_outcome_t   want;
    logic [STAT_W-1:0] got_status;
    logic [ID_W-1:0]   got_id;
    logic              got_done;
    got_status = out_tdata[STAT_W-1:0];
    got_id     = out_tdata[STAT_W +: ID_W];
    got_done   = out_tdata[STAT_W + ID_W];
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: result word with nothing expected: status %0d new_id %0d done %0d",
                 $time, got_status, got_id, got_done);
        errors++;
      end else begin
        want = pending_outcomes.pop_front();
        if (got_status != want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, got_status);
          errors++;
        end
        if (got_id != want.new_id) begin
          $display("%0t: new_id expected %0d, got %0d", $time, want.new_id, got_id);
          errors++;
        end
        if (got_done != want.done_res) begin
          $display("%0t: done_res expected %0d, got %0d", $time, want.done_res, got_done);
          errors++;
        end
      end
    end
    if (rx_left == 0) begin
      case ($urandom_range(0, 2))
        0:       rx_style = RX_OPEN;
        1:       rx_style = RX_CHOPPY;
        default: rx_style = RX_CHOKED;
      endcase
      rx_left = $urandom_range(32, 200);
    end else begin
      rx_left--;
    end
    case (rx_style)
      RX_OPEN:   out_tready <= 1'b1;
      RX_CHOPPY: out_tready <= ($urandom_range(0, 2) != 0);
      default:   out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Every function code, id 0, an id never issued, the all-ones word fields, and a
  // timer queried before and after it runs out, at the reset tick period.
  task automatic test_basic_functions();
    logic [ID_W-1:0] id;
    send_word(FUNC_TICK, '0, '0);
    send_word(FUNC_SPARE, {DUR_W{1'b1}}, ID_MAX);
    send_word(FUNC_QUERY, 32'd77, '0);
    send_word(FUNC_QUERY, '0, ID_MAX);
    send_word(FUNC_CREATE, '0, '0);
    id = last_issued;
    send_word(FUNC_QUERY, '0, id);
    // The slot is free again, so the same id is now unknown.
    send_word(FUNC_QUERY, '0, id);
    send_word(FUNC_CREATE, {DUR_W{1'b1}}, ID_MAX);
    send_word(FUNC_CREATE, 32'd3, '0);
    id = last_issued;
    send_word(FUNC_QUERY, '0, id);
    repeat (3) send_word(FUNC_TICK, '0, '0);
    send_word(FUNC_QUERY, '0, id);
  endtask

  // Tick periods at the edges: zero (divides as one), all ones and one.
  task automatic test_period_extremes();
    hold_until_drained();
    set_tick_period('0);
    send_word(FUNC_CREATE, 32'd1, '0);
    send_word(FUNC_QUERY, '0, last_issued);
    hold_until_drained();
    set_tick_period({MPT_W{1'b1}});
    send_word(FUNC_CREATE, {DUR_W{1'b1}}, '0);
    send_word(FUNC_QUERY, '0, last_issued);
    // 2000 ms at the longest period truncates to a single tick.
    send_word(FUNC_CREATE, 32'd2000, '0);
    send_word(FUNC_TICK, '0, '0);
    send_word(FUNC_QUERY, '0, last_issued);
    hold_until_drained();
    set_tick_period(MPT_W'(1));
    send_word(FUNC_CREATE, '0, '0);
    send_word(FUNC_QUERY, '0, last_issued);
  endtask

  // Random traffic at one tick period. A create-heavy mix fills the table so that
  // refused creates show up; halfway through the sender waits for the block to empty.
  task automatic test_random_traffic(input logic [MPT_W-1:0] period, input int count,
                                     input bit create_heavy);
    int create_pct;
    int query_pct;
    int sel;
    create_pct = create_heavy ? 45 : 20;
    query_pct  = create_heavy ? 25 : 30;
    hold_until_drained();
    set_tick_period(period);
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) hold_until_drained();
      sel = $urandom_range(0, 99);
      if (sel < 3)
        send_word(FUNC_SPARE, $urandom(), ID_W'($urandom()));
      else if (sel < 3 + create_pct)
        send_word(FUNC_CREATE, pick_duration(), ID_W'($urandom()));
      else if (sel < 3 + create_pct + query_pct)
        send_word(FUNC_QUERY, $urandom(), pick_query_id());
      else
        send_word(FUNC_TICK, $urandom(), ID_W'($urandom()));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_functions();
    test_period_extremes();
    test_random_traffic(MPT_RESET, 200, 1'b0);
    test_random_traffic(MPT_W'(1000000), 150, 1'b0);
    test_random_traffic(MPT_W'(1), 120, 1'b0);
    test_random_traffic('0, 100, 1'b0);
    test_random_traffic(MPT_W'($urandom_range(1, 1000000)), 180, 1'b1);
    test_random_traffic(MPT_RESET, 150, 1'b0);
    hold_until_drained();
    // Any stray word after the last expected one is caught by the checker.
    repeat (DRAIN_CYCLES) @(posedge clk);
    errors += pending_outcomes.size();
    $display("Sent %0d ticks, %0d creates, %0d queries and %0d spare codes under %0d periods.",
             n_ticks, n_creates, n_queries, n_spare, n_periods + 1);
    $display("Queries found %0d timers run out and %0d unknown ids; %0d creates met a full table.",
             n_expired, n_unknown, n_table_full);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches.", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
